// ===== design/mtpl_pkg.sv =====
// shared types, command codes and control/status bundles of the mesh point locator
package mtpl_pkg;

    localparam logic [1:0] CMD_WR_VERT = 2'd0;
    localparam logic [1:0] CMD_WR_TRI  = 2'd1;
    localparam logic [1:0] CMD_LOCATE  = 2'd2;

    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic signed [15:0] height;
        logic [7:0]         corner_c;
        logic [7:0]         corner_b;
        logic [7:0]         corner_a;
        logic signed [15:0] link_c;
        logic signed [15:0] link_b;
        logic signed [15:0] link_a;
    } tri_entry_t;

    typedef struct packed {
        logic wr_vert;
        logic wr_tri;
        logic q_latch;
        logic clr_step;
        logic clr_done;
        logic q_start;
        logic pop;
        logic pop_fetch;
        logic scan_init;
        logic scan_fetch;
        logic scan_inc;
        logic edge_rd;
        logic edge_diff;
        logic edge_mul;
        logic edge_cmp;
        logic link_init;
        logic link_inc;
        logic mark_rd;
        logic push;
        logic res_hit;
        logic res_scan;
        logic res_none;
        logic out_load;
    } mtpl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic epoch_max;
        logic start_ok;
        logic fifo_busy;
        logic scan_more;
        logic edge_last;
        logic hit;
        logic link_ok;
        logic link_last;
        logic mark_new;
    } mtpl_stat_t;

endpackage

// ===== design/mtpl_ctrl.sv =====
// sequencer of the mesh point locator: search, scan, mark clearing and output handshake
module mtpl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         cmd,
    input  logic               out_stall,
    input  mtpl_pkg::mtpl_stat_t st,
    output mtpl_pkg::mtpl_cmd_t  cm,
    output logic               idle,
    output logic               out_valid
);
    import mtpl_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_QSTART, S_POP, S_POPW, S_ERD, S_EDIFF, S_EMUL, S_ECMP,
        S_TEND, S_LRD, S_LCHK, S_SNEXT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   scan_reg, scan_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign idle      = (state_reg == S_IDLE);
    assign accept    = idle && in_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cm             = '0;
        state_next     = state_reg;
        pend_next      = pend_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_CLR:
            begin
                cm.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    cm.clr_done = 1'b1;
                    pend_next   = 1'b0;
                    state_next  = pend_reg ? S_QSTART : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_WR_VERT: cm.wr_vert = 1'b1;
                        CMD_WR_TRI:  cm.wr_tri  = 1'b1;
                        CMD_LOCATE:
                        begin
                            cm.q_latch = 1'b1;
                            if (st.epoch_max)
                            begin
                                pend_next  = 1'b1;
                                state_next = S_CLR;
                            end
                            else
                            begin
                                state_next = S_QSTART;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_QSTART:
            begin
                scan_next = 1'b0;
                if (st.start_ok)
                begin
                    cm.q_start = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    cm.scan_init = 1'b1;
                    state_next   = S_SNEXT;
                end
            end
            S_POP:
            begin
                if (st.fifo_busy)
                begin
                    cm.pop     = 1'b1;
                    state_next = S_POPW;
                end
                else
                begin
                    cm.scan_init = 1'b1;
                    state_next   = S_SNEXT;
                end
            end
            S_POPW:
            begin
                cm.pop_fetch = 1'b1;
                state_next   = S_ERD;
            end
            S_ERD:
            begin
                cm.edge_rd = 1'b1;
                state_next = S_EDIFF;
            end
            S_EDIFF:
            begin
                cm.edge_diff = 1'b1;
                state_next   = S_EMUL;
            end
            S_EMUL:
            begin
                cm.edge_mul = 1'b1;
                state_next  = S_ECMP;
            end
            S_ECMP:
            begin
                cm.edge_cmp = 1'b1;
                state_next  = st.edge_last ? S_TEND : S_ERD;
            end
            S_TEND:
            begin
                if (st.hit)
                begin
                    cm.res_hit  = 1'b1;
                    cm.res_scan = scan_reg;
                    state_next  = S_DONE;
                end
                else if (scan_reg)
                begin
                    cm.scan_inc = 1'b1;
                    state_next  = S_SNEXT;
                end
                else
                begin
                    cm.link_init = 1'b1;
                    state_next   = S_LRD;
                end
            end
            S_LRD:
            begin
                if (st.link_ok)
                begin
                    cm.mark_rd = 1'b1;
                    state_next = S_LCHK;
                end
                else if (st.link_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cm.link_inc = 1'b1;
                end
            end
            S_LCHK:
            begin
                cm.push = st.mark_new;
                if (st.link_last)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cm.link_inc = 1'b1;
                    state_next  = S_LRD;
                end
            end
            S_SNEXT:
            begin
                scan_next = 1'b1;
                if (st.scan_more)
                begin
                    cm.scan_fetch = 1'b1;
                    state_next    = S_ERD;
                end
                else
                begin
                    cm.res_none = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cm.out_load    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            pend_reg      <= 1'b0;
            scan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/mtpl_dp.sv =====
// datapath of the mesh point locator: mesh memories, search queue, marks and edge tests
module mtpl_dp #(
    parameter int TRI_DEPTH  = 8192,
    parameter int VERT_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mtpl_pkg::mtpl_cmd_t cm,
    output mtpl_pkg::mtpl_stat_t st,
    input  logic                cfg_we,
    input  logic [13:0]         cfg_data,
    input  logic [12:0]         entry_index,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_z,
    input  logic signed [15:0]  floor_level,
    input  logic [7:0]          corner_a,
    input  logic [7:0]          corner_b,
    input  logic [7:0]          corner_c,
    input  logic signed [15:0]  link_a,
    input  logic signed [15:0]  link_b,
    input  logic signed [15:0]  link_c,
    input  logic signed [13:0]  start_tri,
    output logic signed [13:0]  found_tri,
    output logic signed [15:0]  floor_height,
    output logic signed [13:0]  search_steps
);
    import mtpl_pkg::*;

    localparam int TIW = $clog2(TRI_DEPTH);
    localparam int PW  = TIW + 1;
    localparam int VAW = $clog2(VERT_DEPTH);
    localparam int CAP = (TRI_DEPTH < 16383) ? TRI_DEPTH : 16383;

    // memories
    tri_entry_t           tri_mem   [TRI_DEPTH];
    logic [63:0]          vert_mem  [VERT_DEPTH];
    logic [EPOCH_W-1:0]   mark_mem  [TRI_DEPTH];
    logic [TIW-1:0]       fifo_mem  [TRI_DEPTH];

    tri_entry_t           tri_q;
    logic [63:0]          va_q, vb_q;
    logic [EPOCH_W-1:0]   mark_q;
    logic [TIW-1:0]       fifo_q;

    logic [13:0]          num_reg;
    logic [13:0]          count;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [TIW-1:0]       clr_reg;
    logic [PW-1:0]        head_reg, tail_reg, scan_reg;
    logic [TIW-1:0]       cur_reg;
    logic [1:0]           k_reg, j_reg;
    logic                 neg_reg, pos_reg;
    logic signed [31:0]   px_reg, pz_reg;
    logic signed [13:0]   start_reg;
    logic signed [32:0]   d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [65:0]   p1_reg, p2_reg;
    logic signed [66:0]   pdiff;
    logic signed [13:0]   res_tri_reg, res_steps_reg;
    logic signed [15:0]   res_h_reg;
    logic signed [13:0]   out_tri_reg, out_steps_reg;
    logic signed [15:0]   out_h_reg;

    logic [VAW-1:0]       mod_lut [256];
    logic [7:0]           corner_k, corner_k1;
    logic signed [15:0]   link_sel;
    logic [16:0]          link_ext, start_ext, slot_ext, cur_ext, head_m1;
    logic [TIW-1:0]       link_idx, start_idx;

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_mod
        assign mod_lut[gi] = VAW'(gi % VERT_DEPTH);
    end

    assign count = (num_reg > 14'(CAP)) ? 14'(CAP) : num_reg;

    always_comb
    begin
        case (k_reg)
            2'd0:    begin corner_k = tri_q.corner_a; corner_k1 = tri_q.corner_b; end
            2'd1:    begin corner_k = tri_q.corner_b; corner_k1 = tri_q.corner_c; end
            default: begin corner_k = tri_q.corner_c; corner_k1 = tri_q.corner_a; end
        endcase
        case (j_reg)
            2'd0:    link_sel = tri_q.link_a;
            2'd1:    link_sel = tri_q.link_b;
            default: link_sel = tri_q.link_c;
        endcase
    end

    assign link_ext  = {1'b0, link_sel};
    assign link_idx  = link_ext[TIW-1:0];
    assign start_ext = {{3{start_reg[13]}}, start_reg};
    assign start_idx = start_ext[TIW-1:0];
    assign slot_ext  = {4'b0, entry_index};
    assign cur_ext   = 17'(cur_reg);
    assign head_m1   = 17'(head_reg) - 17'd1;
    assign pdiff     = 67'(p1_reg) - 67'(p2_reg);

    assign st.clr_last  = (clr_reg == TIW'(TRI_DEPTH - 1));
    assign st.epoch_max = (epoch_reg == {EPOCH_W{1'b1}});
    assign st.start_ok  = !start_reg[13] && (start_reg[12:0] < count[12:0] || count[13]);
    assign st.fifo_busy = (head_reg < tail_reg);
    assign st.scan_more = (17'(scan_reg) < 17'(count));
    assign st.edge_last = (k_reg == 2'd2);
    assign st.hit       = !(neg_reg && pos_reg);
    assign st.link_ok   = !link_sel[15] && (link_sel[14:0] < 15'(count));
    assign st.link_last = (j_reg == 2'd2);
    assign st.mark_new  = (mark_q != epoch_reg) && (tail_reg < PW'(TRI_DEPTH));

    // mesh memories
    always_ff @(posedge clk)
    begin
        if (cm.wr_vert && slot_ext < 17'(VERT_DEPTH))
            vert_mem[entry_index[VAW-1:0]] <= {coord_x, coord_z};
        if (cm.edge_rd)
        begin
            va_q <= vert_mem[mod_lut[corner_k]];
            vb_q <= vert_mem[mod_lut[corner_k1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm.wr_tri && slot_ext < 17'(TRI_DEPTH))
            tri_mem[slot_ext[TIW-1:0]] <= '{floor_level, corner_c, corner_b, corner_a,
                                             link_c, link_b, link_a};
        if (cm.pop_fetch)
            tri_q <= tri_mem[fifo_q];
        else if (cm.scan_fetch)
            tri_q <= tri_mem[scan_reg[TIW-1:0]];
    end

    // queued marks, tagged with the query epoch
    always_ff @(posedge clk)
    begin
        if (cm.clr_step)
            mark_mem[clr_reg] <= '0;
        else if (cm.q_start)
            mark_mem[start_idx] <= epoch_reg;
        else if (cm.push)
            mark_mem[link_idx] <= epoch_reg;
        if (cm.mark_rd)
            mark_q <= mark_mem[link_idx];
    end

    // search queue
    always_ff @(posedge clk)
    begin
        if (cm.q_start)
            fifo_mem[0] <= start_idx;
        else if (cm.push)
            fifo_mem[tail_reg[TIW-1:0]] <= link_idx;
        if (cm.pop)
            fifo_q <= fifo_mem[head_reg[TIW-1:0]];
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg   <= '0;
            epoch_reg <= '0;
            clr_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            scan_reg  <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                num_reg <= cfg_data;
            if (cm.q_latch)
                epoch_reg <= epoch_reg + 1'b1;
            else if (cm.clr_done)
                epoch_reg <= EPOCH_W'(1);
            if (cm.clr_done)
                clr_reg <= '0;
            else if (cm.clr_step)
                clr_reg <= clr_reg + 1'b1;
            if (cm.q_start)
            begin
                head_reg <= '0;
                tail_reg <= PW'(1);
            end
            else
            begin
                if (cm.pop)
                    head_reg <= head_reg + 1'b1;
                if (cm.push)
                    tail_reg <= tail_reg + 1'b1;
            end
            if (cm.scan_init)
                scan_reg <= '0;
            else if (cm.scan_inc)
                scan_reg <= scan_reg + 1'b1;
            if (cm.pop_fetch || cm.scan_fetch)
                k_reg <= '0;
            else if (cm.edge_cmp)
                k_reg <= k_reg + 1'b1;
            if (cm.link_init)
                j_reg <= '0;
            else if (cm.link_inc)
                j_reg <= j_reg + 1'b1;
        end
    end

    // edge test pipeline and result registers
    always_ff @(posedge clk)
    begin
        if (cm.q_latch)
        begin
            px_reg    <= coord_x;
            pz_reg    <= coord_z;
            start_reg <= start_tri;
        end
        if (cm.pop_fetch)
            cur_reg <= fifo_q;
        else if (cm.scan_fetch)
            cur_reg <= scan_reg[TIW-1:0];
        if (cm.pop_fetch || cm.scan_fetch)
        begin
            neg_reg <= 1'b0;
            pos_reg <= 1'b0;
        end
        else if (cm.edge_cmp)
        begin
            if (pdiff < 0)
                neg_reg <= 1'b1;
            if (pdiff > 0)
                pos_reg <= 1'b1;
        end
        if (cm.edge_diff)
        begin
            d1_reg <= 33'(signed'(vb_q[63:32])) - 33'(signed'(va_q[63:32]));
            d2_reg <= 33'(pz_reg) - 33'(signed'(va_q[31:0]));
            d3_reg <= 33'(signed'(vb_q[31:0])) - 33'(signed'(va_q[31:0]));
            d4_reg <= 33'(px_reg) - 33'(signed'(va_q[63:32]));
        end
        if (cm.edge_mul)
        begin
            p1_reg <= 66'(d1_reg) * 66'(d2_reg);
            p2_reg <= 66'(d3_reg) * 66'(d4_reg);
        end
        if (cm.res_hit)
        begin
            res_tri_reg   <= cur_ext[13:0];
            res_h_reg     <= tri_q.height;
            res_steps_reg <= cm.res_scan ? -14'sd1 : head_m1[13:0];
        end
        else if (cm.res_none)
        begin
            res_tri_reg   <= -14'sd1;
            res_h_reg     <= '0;
            res_steps_reg <= -14'sd1;
        end
        if (cm.out_load)
        begin
            out_tri_reg   <= res_tri_reg;
            out_h_reg     <= res_h_reg;
            out_steps_reg <= res_steps_reg;
        end
    end

    assign found_tri    = out_tri_reg;
    assign floor_height = out_h_reg;
    assign search_steps = out_steps_reg;

endmodule

// ===== design/mesh_triangle_point_locator.sv =====
// top level of the floor-mesh point locator
//
// one request channel (in_valid / in_stall) carries three commands: write
// vertex, write triangle and locate. a locate walks the mesh breadth-first
// from start_tri over the neighbour links, then falls back to a linear scan
// of all triangles in use if nothing was hit or start_tri is out of range.
// each triangle tested runs each of its edges through vertex read, difference,
// multiply and compare on the single shared cross-product unit, then a
// decide step; a walk adds a queue pop and fetch per triangle and a link
// read per neighbour link, with a mark check for a link in range, and a scan
// adds a fetch per triangle.
// one result request per locate on out_valid / out_stall; the result sits in
// an output register, so a new request is taken while it waits to be taken.
// a stalled result is held unchanged until out_stall drops.
// after reset the queued-mark memory is cleared with in_stall high; every
// 255 locates it is cleared again the same way.
// cfg_valid writes the triangle count from cfg_data; cfg_ready is always high.
module mesh_triangle_point_locator #(
    parameter int TRI_DEPTH  = 8192,
    parameter int VERT_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [12:0]        entry_index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_z,
    input  logic signed [15:0] floor_level,
    input  logic [7:0]         corner_a,
    input  logic [7:0]         corner_b,
    input  logic [7:0]         corner_c,
    input  logic signed [15:0] link_a,
    input  logic signed [15:0] link_b,
    input  logic signed [15:0] link_c,
    input  logic signed [13:0] start_tri,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] found_tri,
    output logic signed [15:0] floor_height,
    output logic signed [13:0] search_steps,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [13:0]        cfg_data
);
    import mtpl_pkg::*;

    mtpl_cmd_t  cm;
    mtpl_stat_t st;
    logic       idle;

    // config register can be written at any time
    assign cfg_ready = 1'b1;
    // requests are taken only while the sequencer waits
    assign in_stall  = !idle;

    mtpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .st        (st),
        .cm        (cm),
        .idle      (idle),
        .out_valid (out_valid)
    );

    mtpl_dp #(
        .TRI_DEPTH  (TRI_DEPTH),
        .VERT_DEPTH (VERT_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cm           (cm),
        .st           (st),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .entry_index  (entry_index),
        .coord_x      (coord_x),
        .coord_z      (coord_z),
        .floor_level  (floor_level),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .link_a       (link_a),
        .link_b       (link_b),
        .link_c       (link_c),
        .start_tri    (start_tri),
        .found_tri    (found_tri),
        .floor_height (floor_height),
        .search_steps (search_steps)
    );

endmodule

// ===== test/mesh_triangle_point_locator_tb.sv =====
// testbench of the floor-mesh point locator: random and directed requests checked against a predictor
`timescale 1ns / 1ps

module mesh_triangle_point_locator_tb;
    import mtpl_pkg::*;

    localparam int TRI_N  = 8192;
    localparam int VERT_N = 256;
    localparam int BASE_TRIS = 64;     // triangles 0 .. BASE_TRIS-1 are always written

    // one request as the sender sees it
    typedef struct {
        logic [1:0]         cmd;
        logic [12:0]        slot;
        logic signed [31:0] px;
        logic signed [31:0] pz;
        logic signed [15:0] level;
        logic [7:0]         ca;
        logic [7:0]         cb;
        logic [7:0]         cc;
        logic signed [15:0] la;
        logic signed [15:0] lb;
        logic signed [15:0] lc;
        logic signed [13:0] start;
    } mesh_req_t;

    // one locate answer
    typedef struct {
        logic signed [13:0] tri_id;
        logic signed [15:0] height;
        logic signed [13:0] steps;
    } locate_ans_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [12:0]        entry_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
    logic signed [15:0] floor_level;
    logic [7:0]         corner_a;
    logic [7:0]         corner_b;
    logic [7:0]         corner_c;
    logic signed [15:0] link_a;
    logic signed [15:0] link_b;
    logic signed [15:0] link_c;
    logic signed [13:0] start_tri;
    logic               out_valid;
    logic               out_stall;
    logic signed [13:0] found_tri;
    logic signed [15:0] floor_height;
    logic signed [13:0] search_steps;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [13:0]        cfg_data;

    mesh_triangle_point_locator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .entry_index  (entry_index),
        .coord_x      (coord_x),
        .coord_z      (coord_z),
        .floor_level  (floor_level),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .link_a       (link_a),
        .link_b       (link_b),
        .link_c       (link_c),
        .start_tri    (start_tri),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found_tri    (found_tri),
        .floor_height (floor_height),
        .search_steps (search_steps),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // predictor copy of the mesh
    logic signed [31:0] mesh_vx [VERT_N];
    logic signed [31:0] mesh_vz [VERT_N];
    logic signed [15:0] mesh_height [TRI_N];
    logic [7:0]         mesh_corner [TRI_N][3];
    logic signed [15:0] mesh_link [TRI_N][3];
    bit                 walk_mark [TRI_N];
    logic [13:0]        tri_count_reg;

    locate_ans_t pending_answers [$];
    int          mismatch_count;

    // traffic shaping, changed by the tests
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_request;          // a long receiver hold-off, in cycles
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // -------------------------------------------------------------------
    // predictor
    // -------------------------------------------------------------------

    // sign of d1*d2 - d3*d4, exact for the 33-bit differences of 32-bit coordinates
    function automatic int cross_sign(logic signed [69:0] d1, logic signed [69:0] d2,
                                      logic signed [69:0] d3, logic signed [69:0] d4);
        logic signed [69:0] v;
        v = d1 * d2 - d3 * d4;
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // inside test: the edge signs never include both a negative and a positive, so either winding passes
    function automatic bit tri_holds(int t, logic signed [31:0] px, logic signed [31:0] pz);
        bit neg;
        bit pos;
        int ia;
        int ib;
        int s;
        neg = 0;
        pos = 0;
        for (int k = 0; k < 3; k++)
        begin
            ia = mesh_corner[t][k];
            ib = mesh_corner[t][(k + 1) % 3];
            s = cross_sign(70'(mesh_vx[ib]) - 70'(mesh_vx[ia]), 70'(pz) - 70'(mesh_vz[ia]),
                           70'(mesh_vz[ib]) - 70'(mesh_vz[ia]), 70'(px) - 70'(mesh_vx[ia]));
            if (s < 0) neg = 1;
            if (s > 0) pos = 1;
        end
        return !(neg && pos);
    endfunction

    function automatic int tris_in_use();
        return (tri_count_reg < TRI_N) ? int'(tri_count_reg) : TRI_N;
    endfunction

    // breadth-first walk over the links, then the linear scan as fallback
    function automatic locate_ans_t predict_locate(logic signed [31:0] px,
                                                   logic signed [31:0] pz,
                                                   logic signed [13:0] start);
        locate_ans_t ans;
        int work [$];
        int n_use;
        int popped;
        int t;
        int nb;
        int hit;
        int steps;
        n_use = tris_in_use();
        hit = -1;
        steps = -1;
        if (start >= 0 && int'(start) < n_use)
        begin
            foreach (walk_mark[i]) walk_mark[i] = 0;
            work.push_back(int'(start));
            walk_mark[int'(start)] = 1;
            popped = 0;
            while (work.size() > 0 && hit < 0)
            begin
                t = work.pop_front();
                popped++;
                if (tri_holds(t, px, pz))
                begin
                    hit = t;
                    steps = popped - 1;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        nb = int'(mesh_link[t][k]);
                        if (nb >= 0 && nb < n_use && !walk_mark[nb])
                        begin
                            walk_mark[nb] = 1;
                            work.push_back(nb);
                        end
                    end
                end
            end
        end
        if (hit < 0)
        begin
            steps = -1;
            for (int i = 0; i < n_use && hit < 0; i++)
                if (tri_holds(i, px, pz)) hit = i;
        end
        ans.tri_id = 14'(hit);
        ans.height = (hit >= 0) ? mesh_height[hit] : 16'sd0;
        ans.steps  = 14'(steps);
        return ans;
    endfunction

    // apply an accepted request to the predictor
    function automatic void predict_request(mesh_req_t r);
        case (r.cmd)
            CMD_WR_VERT:
                if (r.slot < VERT_N)
                begin
                    mesh_vx[r.slot] = r.px;
                    mesh_vz[r.slot] = r.pz;
                end
            CMD_WR_TRI:
            begin
                mesh_height[r.slot]    = r.level;
                mesh_corner[r.slot][0] = r.ca;
                mesh_corner[r.slot][1] = r.cb;
                mesh_corner[r.slot][2] = r.cc;
                mesh_link[r.slot][0]   = r.la;
                mesh_link[r.slot][1]   = r.lb;
                mesh_link[r.slot][2]   = r.lc;
            end
            CMD_LOCATE:
                pending_answers.push_back(predict_locate(r.px, r.pz, r.start));
            default: ;   // command three does nothing
        endcase
    endfunction

    // -------------------------------------------------------------------
    // receiver side and result check
    // -------------------------------------------------------------------

    // random stall, or a counted hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        locate_ans_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result with no request pending", found_tri, -1);
            else
            begin
                want = pending_answers.pop_front();
                if (found_tri !== want.tri_id)
                    report_mismatch("found_tri", found_tri, want.tri_id);
                if (floor_height !== want.height)
                    report_mismatch("floor_height", floor_height, want.height);
                if (search_steps !== want.steps)
                    report_mismatch("search_steps", search_steps, want.steps);
            end
        end
    end

    // -------------------------------------------------------------------
    // sender side
    // -------------------------------------------------------------------

    // offer one request and wait until it is taken; valid stays high afterwards
    task automatic send_request(mesh_req_t r);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= r.cmd;
        entry_index <= r.slot;
        coord_x     <= r.px;
        coord_z     <= r.pz;
        floor_level <= r.level;
        corner_a    <= r.ca;
        corner_b    <= r.cb;
        corner_c    <= r.cc;
        link_a      <= r.la;
        link_b      <= r.lb;
        link_c      <= r.lc;
        start_tri   <= r.start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_request(r);
    endtask

    // drop valid and let every pending answer arrive
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_answers.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_tri_count(int n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= 14'(n);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tri_count_reg = 14'(n);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic mesh_req_t vert_req(int slot, int x, int z);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = CMD_WR_VERT;
        r.slot = 13'(slot);
        r.px = x;
        r.pz = z;
        return r;
    endfunction

    function automatic mesh_req_t tri_req(int slot, int lvl, int a, int b, int c,
                                          int la, int lb, int lc);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = CMD_WR_TRI;
        r.slot = 13'(slot);
        r.level = 16'(lvl);
        r.ca = 8'(a);
        r.cb = 8'(b);
        r.cc = 8'(c);
        r.la = 16'(la);
        r.lb = 16'(lb);
        r.lc = 16'(lc);
        return r;
    endfunction

    function automatic mesh_req_t locate_req(int x, int z, int start);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = CMD_LOCATE;
        r.px = x;
        r.pz = z;
        r.start = 14'(start);
        return r;
    endfunction

    function automatic int small_coord();
        return $urandom_range(0, 200) - 100;
    endfunction

    function automatic int random_link(int n_use);
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return -1;
        if (pick < 20) return $urandom;        // full 16-bit noise
        return $urandom_range(0, n_use + 2);
    endfunction

    // a random triangle, points clustered so hits are common
    function automatic mesh_req_t random_tri(int slot, int n_use);
        return tri_req(slot, $urandom, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), random_link(n_use), random_link(n_use),
                       random_link(n_use));
    endfunction

    function automatic mesh_req_t random_request();
        mesh_req_t r;
        int pick;
        int n_use;
        int v;
        n_use = tris_in_use();
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // vertex rewrite, sometimes to a slot past the table
            if ($urandom_range(3) == 0)
                r = vert_req($urandom_range(VERT_N, TRI_N - 1), $urandom, $urandom);
            else if ($urandom_range(15) == 0)
                r = vert_req($urandom_range(0, 255), $urandom, $urandom);
            else
                r = vert_req($urandom_range(0, 255), small_coord(), small_coord());
        end
        else if (pick < 18)
        begin
            if ($urandom_range(7) == 0)
                r = random_tri($urandom_range(0, TRI_N - 1), n_use);
            else
                r = random_tri($urandom_range(0, BASE_TRIS - 1), n_use);
        end
        else if (pick < 21)
        begin
            // command three with random payload, ignored
            r = random_tri($urandom, n_use);
            r.cmd = 2'b11;
            r.px = $urandom;
            r.start = 14'($urandom);
        end
        else
        begin
            v = $urandom_range(0, 255);
            case ($urandom_range(5))
                0: r = locate_req(mesh_vx[v], mesh_vz[v], $urandom_range(0, n_use));
                1: r = locate_req($urandom, $urandom, $urandom_range(0, n_use));
                2: r = locate_req(small_coord(), small_coord(), $urandom);
                default: r = locate_req(small_coord(), small_coord(),
                                        int'($urandom_range(0, n_use + 1)) - 1);
            endcase
        end
        return r;
    endfunction

    // -------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------

    task automatic test_base_mesh();
        // empty mesh answers none before anything is loaded
        send_request(locate_req(0, 0, 0));
        send_request(locate_req(5, -5, -1));
        for (int i = 0; i < VERT_N; i++)
            send_request(vert_req(i, small_coord(), small_coord()));
        for (int i = 0; i < BASE_TRIS; i++)
            send_request(random_tri(i, 24));
    endtask

    task automatic test_directed();
        set_tri_count(8);
        // known square split in two: vertices 0..3, triangles 0 and 1
        send_request(vert_req(0, 0, 0));
        send_request(vert_req(1, 10, 0));
        send_request(vert_req(2, 10, 10));
        send_request(vert_req(3, 0, 10));
        send_request(vert_req(300, 999, 999));                 // slot past the table
        send_request(tri_req(0, 32767, 0, 1, 2, 1, -1, 32767));
        send_request(tri_req(1, -32768, 0, 3, 2, 0, -32768, 7));  // other winding
        send_request(locate_req(2, 8, 0));                     // found by the walk
        send_request(locate_req(8, 2, 1));
        send_request(locate_req(8, 2, -1));                    // start below range
        send_request(locate_req(8, 2, 8));                     // start past count
        send_request(locate_req(8, 2, -8192));
        send_request(locate_req(5, 5, 8191));                  // on the shared edge
        send_request(locate_req(0, 0, 1));                     // on a corner
        // extreme coordinates, edge differences beyond 32 bits
        send_request(vert_req(254, 32'h8000_0000, 32'h8000_0000));
        send_request(vert_req(255, 32'h7fff_ffff, 32'h7fff_ffff));
        send_request(vert_req(253, 32'h7fff_ffff, 32'h8000_0000));
        send_request(tri_req(2, 1234, 254, 255, 253, 3, 2, 0));
        send_request(tri_req(3, 77, 5, 5, 5, -1, -1, -1));     // point-sized triangle
        send_request(locate_req(32'h7fff_fffe, 32'h8000_0001, 2));
        send_request(locate_req(32'h8000_0000, 32'h7fff_ffff, 2));
        send_request(locate_req(32'h8000_0000, 32'h8000_0000, 3));
        send_request(mesh_req_t'{cmd: 2'b11, slot: '1, px: '1, pz: '1, level: '1, ca: '1,
                                 cb: '1, cc: '1, la: '1, lb: '1, lc: '1, start: '1});
        send_request(locate_req(3, 3, 0));
    endtask

    task automatic test_random_phase(int items, int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int i = 0; i < items; i++)
        begin
            // reconfigure now and then, always within the written triangles
            if (i % 100 == 99)
                set_tri_count($urandom_range(0, 4) == 0 ? 1 : $urandom_range(1, 24));
            send_request(random_request());
        end
        drain();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        set_tri_count(16);
        hold_request = 600;
        for (int i = 0; i < 40; i++)
            send_request(locate_req(small_coord(), small_coord(), $urandom_range(0, 16)));
        drain();
    endtask

    // top slots written, then the count at and past the table size; each locate at
    // those counts sits on a corner of a written triangle so nothing unwritten is read
    task automatic test_full_mesh();
        int v;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        for (int i = TRI_N - 8; i < TRI_N; i++)
            send_request(tri_req(i, $urandom, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), -1, -1, -1));
        set_tri_count(TRI_N);
        for (int i = 0; i < 6; i++)
        begin
            v = $urandom_range(TRI_N - 8, TRI_N - 1);
            send_request(locate_req(mesh_vx[mesh_corner[v][0]], mesh_vz[mesh_corner[v][0]],
                                    v));
        end
        set_tri_count(16383);
        v = TRI_N - 1;
        send_request(locate_req(mesh_vx[mesh_corner[v][1]], mesh_vz[mesh_corner[v][1]], 8191));
        // scan from triangle zero, which holds the point
        send_request(locate_req(mesh_vx[mesh_corner[0][2]], mesh_vz[mesh_corner[0][2]], -1));
        set_tri_count(0);
        send_request(locate_req(0, 0, 0));
        set_tri_count(BASE_TRIS);
        test_random_phase(40, 30, 30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_WR_VERT;
        entry_index = '0;
        coord_x = '0;
        coord_z = '0;
        floor_level = '0;
        corner_a = '0;
        corner_b = '0;
        corner_c = '0;
        link_a = '0;
        link_b = '0;
        link_c = '0;
        start_tri = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tri_count_reg = '0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_base_mesh();
        test_directed();
        set_tri_count(20);
        test_random_phase(300, 0, 0);
        test_random_phase(300, 77, 0);
        test_random_phase(300, 0, 77);
        test_random_phase(300, 9, 9);
        test_backpressure();
        test_full_mesh();

        drain();
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
